[hw/rtl/tap_pkg.sv]
// Shared types and codes for the threshold alarm block.
`default_nettype none

package tap_pkg;

	// Default sizing
	localparam int unsigned NUM_JOBS_DEF         = 8;
	localparam int unsigned TICKS_PER_SECOND_DEF = 128;

	// Register reset value
	localparam logic [15:0] CHECK_INTERVAL_RST = 16'd128;

	// Command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_CHECK = 1'b1;

	// Sensor source codes
	localparam logic [2:0] SRC_LIGHT = 3'd0;
	localparam logic [2:0] SRC_TEMP  = 3'd1;
	localparam logic [2:0] SRC_POWER = 3'd2;
	localparam logic [2:0] SRC_UPTIME = 3'd3;
	localparam logic [2:0] SRC_RSSI  = 3'd4;

	// Compare operator codes
	localparam logic [2:0] OP_GT = 3'd0;
	localparam logic [2:0] OP_GE = 3'd1;
	localparam logic [2:0] OP_LT = 3'd2;
	localparam logic [2:0] OP_LE = 3'd3;
	localparam logic [2:0] OP_EQ = 3'd4;

	// Request payload
	typedef struct packed {
		logic               command;
		logic [2:0]         job_index;
		logic               job_enable;
		logic [2:0]         job_source;
		logic [2:0]         job_operator;
		logic signed [31:0] job_threshold;
		logic [15:0]        job_duration_s;
		logic [15:0]        light_sample;
		logic signed [15:0] temperature_sample;
		logic [15:0]        power_sample;
		logic [30:0]        uptime_sample;
		logic signed [7:0]  rssi_sample;
	} tap_req_t;

	// Response payload
	typedef struct packed {
		logic [7:0] fired_mask;
		logic [7:0] active_mask;
	} tap_rsp_t;

	// One stored job
	typedef struct packed {
		logic [2:0]         source;
		logic [2:0]         oper;
		logic signed [31:0] threshold;
		logic [15:0]        duration;
	} tap_job_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       load_job;
		logic       start_check;
		logic       issue;
		logic [2:0] idx;
	} tap_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic s1_busy;
	} tap_stat_t;

endpackage

`default_nettype wire

[hw/rtl/tap_dpath.sv]
// Datapath: job table, elapsed counters and the two-stage compare and update pipe.
`default_nettype none

module tap_dpath #(
	parameter int unsigned NUM_JOBS         = tap_pkg::NUM_JOBS_DEF,
	parameter int unsigned TICKS_PER_SECOND = tap_pkg::TICKS_PER_SECOND_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tap_pkg::tap_cmd_t cmd,
	input  wire tap_pkg::tap_req_t req,
	input  wire logic              cfg_we,
	input  wire logic [15:0]       cfg_data,
	output tap_pkg::tap_stat_t     stat,
	output tap_pkg::tap_rsp_t      rsp
);
	import tap_pkg::*;

	localparam int unsigned IDX_W = (NUM_JOBS > 1) ? $clog2(NUM_JOBS) : 1;
	localparam logic [15:0] TPS   = 16'(TICKS_PER_SECOND);

	// State
	logic [15:0]        interval_q;
	logic               valid_q    [NUM_JOBS];
	tap_job_t           settings_q [NUM_JOBS];
	logic [31:0]        elapsed_q  [NUM_JOBS];
	logic [15:0]        light_q;
	logic signed [15:0] temp_q;
	logic [15:0]        power_q;
	logic [30:0]        uptime_q;
	logic signed [7:0]  rssi_q;
	logic [7:0]         fired_q;
	logic [7:0]         active_q;

	// Pipe stage 1
	logic             v_s1;
	logic             en_s1;
	logic             met_s1;
	logic [31:0]      limit_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             wr_ok;
	logic [IDX_W-1:0] wr_idx;
	logic [IDX_W-1:0] rd_idx;
	tap_job_t         rd;
	logic signed [31:0] sample_c;
	logic             src_ok;
	logic             cmp_c;
	logic [31:0]      limit_c;
	logic [32:0]      sum_c;
	logic [31:0]      new_el;
	logic             fire_c;

	assign wr_ok  = ({29'd0, req.job_index} < NUM_JOBS);
	assign wr_idx = req.job_index[IDX_W-1:0];
	assign rd_idx = cmd.idx[IDX_W-1:0];
	assign rd     = settings_q[rd_idx];

	// Sample selection
	always_comb begin
		src_ok   = 1'b1;
		sample_c = '0;
		unique case (rd.source)
			SRC_LIGHT:  sample_c = {16'd0, light_q};
			SRC_TEMP:   sample_c = {{16{temp_q[15]}}, temp_q};
			SRC_POWER:  sample_c = {16'd0, power_q};
			SRC_UPTIME: sample_c = {1'b0, uptime_q};
			SRC_RSSI:   sample_c = {{24{rssi_q[7]}}, rssi_q};
			default:    src_ok = 1'b0;
		endcase
	end

	// Threshold compare, unknown operator never met
	always_comb begin
		unique case (rd.oper)
			OP_GT:   cmp_c = sample_c >  rd.threshold;
			OP_GE:   cmp_c = sample_c >= rd.threshold;
			OP_LT:   cmp_c = sample_c <  rd.threshold;
			OP_LE:   cmp_c = sample_c <= rd.threshold;
			OP_EQ:   cmp_c = sample_c == rd.threshold;
			default: cmp_c = 1'b0;
		endcase
	end

	assign limit_c = {16'd0, rd.duration} * {16'd0, TPS};

	// Stage 2: saturating accumulate and fire test
	always_comb begin
		sum_c  = {1'b0, elapsed_q[idx_s1]} + {17'd0, interval_q};
		new_el = '0;
		if (met_s1) begin
			new_el = sum_c[32] ? '1 : sum_c[31:0];
		end
		fire_c = (new_el >= limit_s1);
	end

	// Config register and stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= CHECK_INTERVAL_RST;
			v_s1       <= 1'b0;
		end else begin
			if (cfg_we) begin
				interval_q <= cfg_data;
			end
			v_s1 <= cmd.issue;
		end
	end

	// Job valid bits and elapsed counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_JOBS; i++) begin
				valid_q[i]   <= 1'b0;
				elapsed_q[i] <= '0;
			end
		end else begin
			priority if (cmd.load_job && wr_ok) begin
				valid_q[wr_idx]   <= req.job_enable;
				elapsed_q[wr_idx] <= '0;
			end else if (v_s1 && en_s1) begin
				elapsed_q[idx_s1] <= fire_c ? 32'd0 : new_el;
			end
		end
	end

	// Job settings, no reset
	always_ff @(posedge clk) begin
		if (cmd.load_job && wr_ok) begin
			settings_q[wr_idx] <= '{source:    req.job_source,
			                       oper:      req.job_operator,
			                       threshold: req.job_threshold,
			                       duration:  req.job_duration_s};
		end
	end

	// Sample capture, stage 1 payload, result masks
	always_ff @(posedge clk) begin
		if (cmd.start_check) begin
			light_q  <= req.light_sample;
			temp_q   <= req.temperature_sample;
			power_q  <= req.power_sample;
			uptime_q <= req.uptime_sample;
			rssi_q   <= req.rssi_sample;
			fired_q  <= '0;
			active_q <= '0;
		end else if (v_s1 && en_s1) begin
			fired_q[idx_s1]  <= fire_c;
			active_q[idx_s1] <= met_s1;
		end
		if (cmd.issue) begin
			en_s1    <= valid_q[rd_idx];
			met_s1   <= src_ok && cmp_c;
			limit_s1 <= limit_c;
			idx_s1   <= rd_idx;
		end
	end

	assign stat.s1_busy    = v_s1;
	assign rsp.fired_mask  = fired_q;
	assign rsp.active_mask = active_q;

endmodule

`default_nettype wire

[hw/rtl/tap_ctrl.sv]
// Controller: sequences a check over the job table and holds the response valid.
`default_nettype none

module tap_ctrl #(
	parameter int unsigned NUM_JOBS = tap_pkg::NUM_JOBS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	input  wire logic               req_command,
	output logic                    req_stall,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	input  wire tap_pkg::tap_stat_t stat,
	output tap_pkg::tap_cmd_t       cmd
);
	import tap_pkg::*;

	localparam int unsigned IDX_W = (NUM_JOBS > 1) ? $clog2(NUM_JOBS) : 1;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_JOBS - 1);

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		DRAIN,
		DONE
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] cnt_q;
	logic             rsp_valid_q;
	logic             take;

	assign req_stall = (state_q != IDLE);
	assign take      = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;

	// Commands to the datapath
	always_comb begin
		cmd             = '0;
		cmd.load_job    = take && (req_command == CMD_WRITE);
		cmd.start_check = take && (req_command == CMD_CHECK);
		cmd.issue       = (state_q == SCAN);
		cmd.idx         = 3'(cnt_q);
	end

	// State and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					cnt_q <= '0;
					if (cmd.start_check) begin
						state_q <= SCAN;
					end
				end
				SCAN: begin
					if (cnt_q == LAST) begin
						state_q <= DRAIN;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				DRAIN: begin
					// last job leaves the update stage here
					if (stat.s1_busy) begin
						state_q     <= DONE;
						rsp_valid_q <= 1'b1;
					end
				end
				DONE: begin
					if (!rsp_stall) begin
						state_q     <= IDLE;
						rsp_valid_q <= 1'b0;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/threshold_alarm_with_persistence.sv]
// Top level of the threshold alarm table with hold time.
`default_nettype none

// Alarm table of NUM_JOBS jobs. A write request loads one job slot and clears
// its elapsed time and returns no response. A check request latches the five
// samples and walks the table one job per cycle through a two-stage pipe
// (select and compare, then accumulate and fire test) before its response is
// offered; the next request is taken in the cycle after the response transfer.
// The job walk sets the length of a check: the table has one read port.
// check_interval_ticks may be written at any cycle while no check is running.
// There is no clearing pass after reset.
module threshold_alarm_with_persistence #(
	parameter int unsigned NUM_JOBS         = tap_pkg::NUM_JOBS_DEF,
	parameter int unsigned TICKS_PER_SECOND = tap_pkg::TICKS_PER_SECOND_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire tap_pkg::tap_req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output tap_pkg::tap_rsp_t      rsp,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [15:0]       cfg_data
);
	import tap_pkg::*;

	tap_cmd_t  cmd;
	tap_stat_t stat;

	assign cfg_ready = 1'b1;

	tap_ctrl #(
		.NUM_JOBS (NUM_JOBS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_command (req.command),
		.req_stall   (req_stall),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.stat        (stat),
		.cmd         (cmd)
	);

	tap_dpath #(
		.NUM_JOBS         (NUM_JOBS),
		.TICKS_PER_SECOND (TICKS_PER_SECOND)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.stat     (stat),
		.rsp      (rsp)
	);

`ifndef SYNTHESIS
	// no request transfer while a response is offered
	assert property (@(posedge clk) disable iff (!arst_n) rsp_valid |-> req_stall)
		else $error("request taken while response pending");

	// a check transfer starts a walk, no response in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.command == CMD_CHECK |=> req_stall && !rsp_valid)
		else $error("check did not start a table walk");

	// mask bits for slots beyond the table stay clear
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((16'(rsp.fired_mask) >> NUM_JOBS) == 16'd0)
		&& ((16'(rsp.active_mask) >> NUM_JOBS) == 16'd0))
		else $error("mask bit set beyond NUM_JOBS");
`endif

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the threshold alarm table: directed rows, then random phases.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tap_pkg::*;

	localparam int NJ       = NUM_JOBS_DEF;
	localparam int TPS      = TICKS_PER_SECOND_DEF;
	localparam int SETTLE   = 12;
	localparam int DRAIN    = 24;
	localparam int WATCHDOG = 5000;
	localparam int PHASES   = 6;
	localparam int PHASE_N  = 205;

	// Codes that the block must treat as never met
	localparam logic [2:0] SRC_NONE = 3'd5;
	localparam logic [2:0] OP_NONE  = 3'd7;

	typedef struct {
		tap_req_t req;
		bit       typed;
		tap_rsp_t want;
	} dir_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	tap_req_t    req       = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	tap_rsp_t    rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data  = '0;

	// Predicted table state
	bit          job_on [NJ];
	tap_job_t    job_tbl [NJ];
	logic [31:0] elapsed [NJ];
	logic [15:0] interval = CHECK_INTERVAL_RST;

	tap_rsp_t    rsp_due [$];
	tap_rsp_t    head;
	dir_row_t    dir_tbl [$];
	logic [15:0] phase_ivl [PHASES];

	// Centre values that random samples and thresholds cluster around
	logic [15:0] light_base, temp_base, power_base;
	logic [30:0] up_base;
	logic [7:0]  rssi_base;

	bit          quiet = 1'b0;
	int unsigned mismatches, n_writes, n_checks, n_rsp, n_fired, n_settings, stuck;

	threshold_alarm_with_persistence u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at response %0d: %s got %0h expected %0h", n_rsp, what, got, want);
		mismatches++;
	endtask

	// Apply one request to the predicted table; a check yields its masks
	task automatic alarm_table_step(input tap_req_t r, output bit has_rsp, output tap_rsp_t res);
		longint      smp [5];
		longint      s, thr, lim;
		logic [32:0] sum;
		bit          met;
		has_rsp = 1'b0;
		res     = '0;
		if (r.command == CMD_WRITE) begin
			n_writes++;
			if (int'(r.job_index) < NJ) begin
				job_on[r.job_index]  = r.job_enable;
				job_tbl[r.job_index] = '{source: r.job_source, oper: r.job_operator,
					threshold: r.job_threshold, duration: r.job_duration_s};
				elapsed[r.job_index] = '0;
			end
		end else begin
			n_checks++;
			smp[0] = longint'({1'b0, r.light_sample});
			smp[1] = longint'($signed(r.temperature_sample));
			smp[2] = longint'({1'b0, r.power_sample});
			smp[3] = longint'({1'b0, r.uptime_sample});
			smp[4] = longint'($signed(r.rssi_sample));
			for (int i = 0; i < NJ; i++) begin
				if (job_on[i]) begin
					met = 1'b0;
					thr = longint'($signed(job_tbl[i].threshold));
					if (job_tbl[i].source <= SRC_RSSI) begin
						s = smp[job_tbl[i].source];
						case (job_tbl[i].oper)
							OP_GT: met = (s > thr);
							OP_GE: met = (s >= thr);
							OP_LT: met = (s < thr);
							OP_LE: met = (s <= thr);
							OP_EQ: met = (s == thr);
							default: met = 1'b0;
						endcase
					end
					// Hold time grows while met, saturating; any miss clears it
					if (met) begin
						sum = {1'b0, elapsed[i]} + 33'(interval);
						elapsed[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
						res.active_mask[i] = 1'b1;
					end else begin
						elapsed[i] = '0;
					end
					lim = longint'(job_tbl[i].duration) * TPS;
					if (longint'(elapsed[i]) >= lim) begin
						res.fired_mask[i] = 1'b1;
						elapsed[i] = '0;
					end
				end
			end
			has_rsp = 1'b1;
		end
	endtask

	function automatic tap_req_t mk_write(input logic [2:0] idx, input logic en,
			input logic [2:0] src, input logic [2:0] op, input logic [31:0] thr,
			input logic [15:0] dur);
		tap_req_t r;
		r = '1;                         // samples all ones: ignored by a write
		r.command        = CMD_WRITE;
		r.job_index      = idx;
		r.job_enable     = en;
		r.job_source     = src;
		r.job_operator   = op;
		r.job_threshold  = thr;
		r.job_duration_s = dur;
		return r;
	endfunction

	function automatic tap_req_t mk_check(input logic [15:0] l, input logic [15:0] t,
			input logic [15:0] p, input logic [30:0] u, input logic [7:0] rs);
		tap_req_t r;
		r = '1;                         // job fields all ones: ignored by a check
		r.command            = CMD_CHECK;
		r.light_sample       = l;
		r.temperature_sample = t;
		r.power_sample       = p;
		r.uptime_sample      = u;
		r.rssi_sample        = rs;
		return r;
	endfunction

	// Mostly close to a centre value, sometimes an extreme or anything at all
	function automatic logic [31:0] shaped(input logic [31:0] base, input logic [31:0] lo,
			input logic [31:0] hi);
		case ($urandom_range(0, 9))
			7: return lo;
			8: return hi;
			9: return $urandom();
			default: return base + 32'($urandom_range(0, 6)) - 32'd3;
		endcase
	endfunction

	task automatic pick_sample_bases();
		light_base = 16'($urandom());
		temp_base  = 16'($urandom());
		power_base = 16'($urandom());
		up_base    = 31'($urandom());
		rssi_base  = 8'($urandom());
	endtask

	function automatic tap_req_t make_item();
		logic [159:0] raw;
		logic [31:0]  centre;
		tap_req_t     r;
		raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		r   = raw[$bits(tap_req_t)-1:0];
		if ($urandom_range(0, 9) < 7) begin
			r.command            = CMD_CHECK;
			r.light_sample       = 16'(shaped({16'b0, light_base}, 32'h0, 32'hFFFF));
			r.temperature_sample = 16'(shaped({16'b0, temp_base}, 32'h8000, 32'h7FFF));
			r.power_sample       = 16'(shaped({16'b0, power_base}, 32'h0, 32'hFFFF));
			r.uptime_sample      = 31'(shaped({1'b0, up_base}, 32'h0, 32'h7FFF_FFFF));
			r.rssi_sample        = 8'(shaped({24'b0, rssi_base}, 32'h80, 32'h7F));
		end else begin
			r.command    = CMD_WRITE;
			r.job_enable = ($urandom_range(0, 19) < 17);
			r.job_source = ($urandom_range(0, 9) == 0) ?
				3'($urandom_range(int'(SRC_NONE), 7)) : 3'($urandom_range(0, int'(SRC_RSSI)));
			r.job_operator = ($urandom_range(0, 9) == 0) ?
				3'($urandom_range(int'(OP_EQ) + 1, int'(OP_NONE))) :
				3'($urandom_range(0, int'(OP_EQ)));
			case (r.job_source)
				SRC_LIGHT:  centre = {16'b0, light_base};
				SRC_TEMP:   centre = {{16{temp_base[15]}}, temp_base};
				SRC_POWER:  centre = {16'b0, power_base};
				SRC_UPTIME: centre = {1'b0, up_base};
				SRC_RSSI:   centre = {{24{rssi_base[7]}}, rssi_base};
				default:    centre = $urandom();
			endcase
			r.job_threshold = shaped(centre, 32'h8000_0000, 32'h7FFF_FFFF);
			// Short hold times so that jobs fire often
			case ($urandom_range(0, 9))
				0, 1: r.job_duration_s = '0;
				8:    r.job_duration_s = 16'($urandom_range(5, 600));
				9:    r.job_duration_s = 16'($urandom());
				default: r.job_duration_s = 16'($urandom_range(1, 4));
			endcase
		end
		return r;
	endfunction

	// One request transfer; the prediction is made when it is taken
	task automatic push_req(input tap_req_t r, input bit typed, input tap_rsp_t want);
		bit       has;
		tap_rsp_t pred;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		alarm_table_step(r, has, pred);
		if (has) begin
			rsp_due.push_back(typed ? want : pred);
			n_fired += $countones(pred.fired_mask);
		end
	endtask

	task automatic hold_until_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (rsp_due.size() != 0);
	endtask

	// Register write, only with the block idle
	task automatic write_interval(input logic [15:0] v);
		hold_until_drained();
		repeat (SETTLE) @(posedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		interval = v;
		n_settings++;
	endtask

	// Response checker
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_due.size() == 0) begin
				flag_mismatch("response with none expected", int'(rsp), 0);
			end else begin
				head = rsp_due.pop_front();
				if (rsp.fired_mask !== head.fired_mask)
					flag_mismatch("fired_mask", int'(rsp.fired_mask),
						int'(head.fired_mask));
				if (rsp.active_mask !== head.active_mask)
					flag_mismatch("active_mask", int'(rsp.active_mask),
						int'(head.active_mask));
			end
			n_rsp++;
		end
	end

	// Receiver stall bursts
	initial begin
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles without any transfer
	initial begin
		@(posedge arst_n);
		while (stuck < WATCHDOG) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
				stuck = 0;
			else
				stuck++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Main sequence
	initial begin
		for (int i = 0; i < NJ; i++) begin
			job_on[i]  = 1'b0;
			elapsed[i] = '0;
		end

		// Directed rows at the reset interval
		dir_tbl.push_back('{mk_check(16'h0, 16'h0, 16'h0, 31'h0, 8'h0), 1'b1, '0});
		dir_tbl.push_back('{mk_check(16'hFFFF, 16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF, 8'hFF), 1'b1, '0});
		// Zero duration fires on every check even though never met
		dir_tbl.push_back('{mk_write(3'd0, 1'b1, SRC_LIGHT, OP_GT, 32'h7FFF_FFFF, 16'd0), 1'b0, '0});
		dir_tbl.push_back('{mk_check(16'hFFFF, 16'h0, 16'h0, 31'h0, 8'h0), 1'b1,
			'{fired_mask: 8'h01, active_mask: 8'h00}});
		// Unknown source and unknown operator count as not met
		dir_tbl.push_back('{mk_write(3'd1, 1'b1, SRC_NONE, OP_GE, 32'h8000_0000, 16'd1), 1'b0, '0});
		dir_tbl.push_back('{mk_write(3'd2, 1'b1, SRC_TEMP, OP_NONE, 32'h0, 16'd1), 1'b0, '0});
		dir_tbl.push_back('{mk_check(16'hFFFF, 16'h0, 16'h0, 31'h0, 8'h0), 1'b1,
			'{fired_mask: 8'h01, active_mask: 8'h00}});
		dir_tbl.push_back('{mk_write(3'd3, 1'b1, SRC_UPTIME, OP_GE, 32'h8000_0000, 16'd1), 1'b0, '0});
		dir_tbl.push_back('{mk_write(3'd4, 1'b1, SRC_RSSI, OP_LT, 32'h0, 16'd2), 1'b0, '0});
		dir_tbl.push_back('{mk_write(3'd5, 1'b1, SRC_POWER, OP_EQ, 32'h0000_FFFF, 16'hFFFF), 1'b0, '0});
		dir_tbl.push_back('{mk_write(3'd6, 1'b1, SRC_TEMP, OP_LE, 32'hFFFF_8000, 16'd3), 1'b0, '0});
		dir_tbl.push_back('{mk_write(3'd7, 1'b1, SRC_LIGHT, OP_GT, 32'h0, 16'd1), 1'b0, '0});
		dir_tbl.push_back('{mk_check(16'hFFFF, 16'h8000, 16'hFFFF, 31'h7FFF_FFFF, 8'h80), 1'b0, '0});
		dir_tbl.push_back('{mk_check(16'hFFFF, 16'h8000, 16'hFFFF, 31'h7FFF_FFFF, 8'h80), 1'b0, '0});
		dir_tbl.push_back('{mk_check(16'h0, 16'h7FFF, 16'h0, 31'h0, 8'h7F), 1'b0, '0});
		// Disabled slots are skipped and keep their elapsed time
		dir_tbl.push_back('{mk_write(3'd0, 1'b0, SRC_NONE, OP_NONE, 32'hFFFF_FFFF, 16'hFFFF), 1'b0, '0});
		dir_tbl.push_back('{mk_check(16'hFFFF, 16'h8000, 16'hFFFF, 31'h7FFF_FFFF, 8'h80), 1'b0, '0});
		dir_tbl.push_back('{mk_write(3'd3, 1'b0, SRC_UPTIME, OP_GE, 32'h8000_0000, 16'd1), 1'b0, '0});
		dir_tbl.push_back('{mk_check(16'hFFFF, 16'h8000, 16'hFFFF, 31'h7FFF_FFFF, 8'h80), 1'b0, '0});
		dir_tbl.push_back('{mk_check(16'h0, 16'h0, 16'h0, 31'h0, 8'h0), 1'b0, '0});

		phase_ivl = '{16'd0, 16'd1, 16'hFFFF, 16'($urandom()), CHECK_INTERVAL_RST,
			16'($urandom_range(1, 1024))};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tbl[i])
			push_req(dir_tbl[i].req, dir_tbl[i].typed, dir_tbl[i].want);

		// Random phases, each under its own interval; the last runs without idling
		for (int p = 0; p < PHASES; p++) begin
			write_interval(phase_ivl[p]);
			pick_sample_bases();
			if (p == PHASES - 1)
				quiet = 1'b1;
			for (int k = 0; k < PHASE_N; k++) begin
				if (!quiet && $urandom_range(0, 63) == 0)
					hold_until_drained();
				if ($urandom_range(0, 49) == 0)
					pick_sample_bases();
				push_req(make_item(), 1'b0, '0);
			end
		end

		hold_until_drained();
		repeat (DRAIN) @(posedge clk);
		if (rsp_due.size() != 0)
			flag_mismatch("responses never returned", rsp_due.size(), 0);

		$display("Ran %0d job writes and %0d checks under %0d interval settings.",
			n_writes, n_checks, n_settings + 1);
		$display("Checked %0d responses carrying %0d job firings.", n_rsp, n_fired);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

[threshold_alarm_with_persistence.f]
hw/rtl/tap_pkg.sv
hw/rtl/tap_dpath.sv
hw/rtl/tap_ctrl.sv
hw/rtl/threshold_alarm_with_persistence.sv
tb/tb_top.sv
